>>> rtl/core/fzs_pkg.sv
package fzs_pkg;

	localparam int HGT_W   = 7;
	localparam int IN_W    = 16;
	localparam int X_W     = 21;
	localparam int RAMP_W  = 21;
	localparam int RECIP_W = 22;
	localparam int PROD_W  = RAMP_W + RECIP_W;
	localparam int DEG_W   = 16;
	localparam int DEN_W   = DEG_W + 2;
	localparam int NUM_W   = DEG_W + HGT_W + 2;
	localparam int Q_W     = 15;
	localparam int FRAC_W  = 8;
	localparam int DIVD_W  = NUM_W + FRAC_W;
	localparam int NUM_MF  = 6;
	localparam int FRONT_STAGES = 5;
	localparam int CFG_AW  = 2;

	// membership slots
	localparam int MF_IL = 0;
	localparam int MF_IM = 1;
	localparam int MF_IH = 2;
	localparam int MF_DL = 3;
	localparam int MF_DM = 4;
	localparam int MF_DH = 5;

	localparam logic [CFG_AW-1:0] CFG_H_NO    = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_H_MAYBE = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_H_YES   = 2'd2;

	localparam logic [HGT_W-1:0] H_NO_RST    = 7'd30;
	localparam logic [HGT_W-1:0] H_MAYBE_RST = 7'd60;
	localparam logic [HGT_W-1:0] H_YES_RST   = 7'd80;

	// income breakpoints, income scaled by 20 (one unit is 8192)
	localparam logic [X_W-1:0] X_5U  = 21'd40960;
	localparam logic [X_W-1:0] X_10U = 21'd81920;
	localparam logic [X_W-1:0] X_12U = 21'd98304;
	localparam logic [X_W-1:0] X_16U = 21'd131072;
	localparam logic [X_W-1:0] X_24U = 21'd196608;
	localparam logic [X_W-1:0] X_28U = 21'd229376;
	localparam logic [X_W-1:0] X_30U = 21'd245760;
	localparam logic [X_W-1:0] X_35U = 21'd286720;

	// debt breakpoints in Q8.8
	localparam logic [IN_W-1:0] Y_10 = 16'd2560;
	localparam logic [IN_W-1:0] Y_25 = 16'd6400;
	localparam logic [IN_W-1:0] Y_30 = 16'd7680;
	localparam logic [IN_W-1:0] Y_48 = 16'd12288;
	localparam logic [IN_W-1:0] Y_52 = 16'd13312;
	localparam logic [IN_W-1:0] Y_70 = 16'd17920;
	localparam logic [IN_W-1:0] Y_75 = 16'd19200;
	localparam logic [IN_W-1:0] Y_90 = 16'd23040;

	// ramp divide by 7, 3, 7, 5, 23, 5 as multiply by reciprocal and shift
	typedef logic [RECIP_W-1:0] recip_t;
	localparam recip_t RECIP [NUM_MF] = '{
		22'd599187, 22'd349526, 22'd599187, 22'd419431, 22'd2917777, 22'd419431
	};
	localparam int RSHIFT [NUM_MF] = '{22, 20, 22, 21, 26, 21};

	typedef enum logic [1:0] {
		DK_ZERO,
		DK_FULL,
		DK_RAMP
	} deg_kind_t;

	typedef struct packed {
		logic [HGT_W-1:0] h_no;
		logic [HGT_W-1:0] h_maybe;
		logic [HGT_W-1:0] h_yes;
	} heights_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} frac_t;

endpackage

>>> rtl/core/fzs_front.sv
module fzs_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [15:0]                    income,
	input  logic [15:0]                    debt,
	input  fzs_pkg::heights_t              heights,
	output logic                           out_valid,
	output fzs_pkg::frac_t                 out_data,
	output logic [2:0]                     inflight
);
	import fzs_pkg::*;

	logic [X_W-1:0]    x;
	deg_kind_t         kind_c  [NUM_MF];
	logic [RAMP_W-1:0] ramp_c  [NUM_MF];

	deg_kind_t         kind_s1 [NUM_MF];
	logic [RAMP_W-1:0] ramp_s1 [NUM_MF];
	deg_kind_t         kind_s2 [NUM_MF];
	logic [PROD_W-1:0] prod_s2 [NUM_MF];
	logic [DEG_W-1:0]  deg_c   [NUM_MF];
	logic [DEG_W-1:0]  deg_s3  [NUM_MF];
	logic [DEG_W-1:0]  sno_c, smay_c, syes_c;
	logic [DEG_W-1:0]  sno_s4, smay_s4, syes_s4;
	frac_t             frac_s5;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;

	function automatic logic [DEG_W-1:0] min2(input logic [DEG_W-1:0] a,
		input logic [DEG_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [DEG_W-1:0] max3(input logic [DEG_W-1:0] a,
		input logic [DEG_W-1:0] b, input logic [DEG_W-1:0] c);
		logic [DEG_W-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	// classify each membership and form the ramp dividend
	always_comb begin
		x = X_W'({income, 4'b0}) + X_W'({income, 2'b0});
		for (int i = 0; i < NUM_MF; i++) begin
			kind_c[i] = DK_ZERO;
			ramp_c[i] = '0;
		end
		if (x <= X_5U) begin
			kind_c[MF_IL] = DK_FULL;
		end else if (x < X_12U) begin
			kind_c[MF_IL] = DK_RAMP;
			ramp_c[MF_IL] = (X_12U - x) << 3;
		end
		if (x <= X_10U) begin
			kind_c[MF_IM] = DK_ZERO;
		end else if (x < X_16U) begin
			kind_c[MF_IM] = DK_RAMP;
			ramp_c[MF_IM] = (x - X_10U) << 2;
		end else if (x <= X_24U) begin
			kind_c[MF_IM] = DK_FULL;
		end else if (x < X_30U) begin
			kind_c[MF_IM] = DK_RAMP;
			ramp_c[MF_IM] = (X_30U - x) << 2;
		end
		if (x >= X_35U) begin
			kind_c[MF_IH] = DK_FULL;
		end else if (x > X_28U) begin
			kind_c[MF_IH] = DK_RAMP;
			ramp_c[MF_IH] = (x - X_28U) << 3;
		end
		if (debt <= Y_10) begin
			kind_c[MF_DL] = DK_FULL;
		end else if (debt < Y_30) begin
			kind_c[MF_DL] = DK_RAMP;
			ramp_c[MF_DL] = RAMP_W'(Y_30 - debt) << 6;
		end
		if (debt <= Y_25) begin
			kind_c[MF_DM] = DK_ZERO;
		end else if (debt < Y_48) begin
			kind_c[MF_DM] = DK_RAMP;
			ramp_c[MF_DM] = RAMP_W'(debt - Y_25) << 8;
		end else if (debt <= Y_52) begin
			kind_c[MF_DM] = DK_FULL;
		end else if (debt < Y_75) begin
			kind_c[MF_DM] = DK_RAMP;
			ramp_c[MF_DM] = RAMP_W'(Y_75 - debt) << 8;
		end
		if (debt >= Y_90) begin
			kind_c[MF_DH] = DK_FULL;
		end else if (debt > Y_70) begin
			kind_c[MF_DH] = DK_RAMP;
			ramp_c[MF_DH] = RAMP_W'(debt - Y_70) << 6;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_MF; i++) begin
			case (kind_s2[i])
				DK_ZERO: deg_c[i] = '0;
				DK_FULL: deg_c[i] = '1;
				DK_RAMP: deg_c[i] = DEG_W'(prod_s2[i] >> RSHIFT[i]);
				default: deg_c[i] = '0;
			endcase
		end
	end

	always_comb begin
		sno_c  = max3(min2(deg_s3[MF_IM], deg_s3[MF_DL]), min2(deg_s3[MF_IH], deg_s3[MF_DL]),
			min2(deg_s3[MF_IH], deg_s3[MF_DM]));
		smay_c = max3(min2(deg_s3[MF_IL], deg_s3[MF_DL]), min2(deg_s3[MF_IM], deg_s3[MF_DM]),
			min2(deg_s3[MF_IH], deg_s3[MF_DH]));
		syes_c = max3(min2(deg_s3[MF_IL], deg_s3[MF_DM]), min2(deg_s3[MF_IL], deg_s3[MF_DH]),
			min2(deg_s3[MF_IM], deg_s3[MF_DH]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_MF; i++) begin
			kind_s1[i] <= kind_c[i];
			ramp_s1[i] <= ramp_c[i];
			kind_s2[i] <= kind_s1[i];
			prod_s2[i] <= PROD_W'(ramp_s1[i]) * PROD_W'(RECIP[i]);
			deg_s3[i]  <= deg_c[i];
		end
		sno_s4  <= sno_c;
		smay_s4 <= smay_c;
		syes_s4 <= syes_c;
		frac_s5.den <= DEN_W'(sno_s4) + DEN_W'(smay_s4) + DEN_W'(syes_s4);
		frac_s5.num <= NUM_W'(heights.h_no) * NUM_W'(sno_s4)
			+ NUM_W'(heights.h_maybe) * NUM_W'(smay_s4)
			+ NUM_W'(heights.h_yes) * NUM_W'(syes_s4);
	end

	assign out_valid = v_s5;
	assign out_data  = frac_s5;
	assign inflight  = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4) + 3'(v_s5);

endmodule

>>> rtl/core/fzs_fifo.sv
module fzs_fifo #(
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  fzs_pkg::frac_t             wr_data,
	output logic                       rd_valid,
	output fzs_pkg::frac_t             rd_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import fzs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	frac_t          mem [DEPTH];
	logic [AW-1:0]  wptr_q, rptr_q;
	logic [CW-1:0]  count_q;
	logic           rd_valid_q;
	frac_t          rd_data_q;
	logic           pop;

	// the back end never stalls, so drain whenever something is queued
	assign pop = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q     <= '0;
			rptr_q     <= '0;
			count_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= pop;
			if (wr_en) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + CW'(wr_en) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wptr_q] <= wr_data;
		end
		if (pop) begin
			rd_data_q <= mem[rptr_q];
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_data  = rd_data_q;
	assign count    = count_q;

endmodule

>>> rtl/core/fzs_back.sv
module fzs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  fzs_pkg::frac_t      in_data,
	output logic                done,
	output logic [14:0]         score,
	output logic                zero_weight
);
	import fzs_pkg::*;

	logic [DIVD_W-1:0] rem_s [Q_W+1];
	logic [DEN_W-1:0]  den_s [Q_W+1];
	logic [Q_W-1:0]    quo_s [Q_W+1];
	logic              v_s   [Q_W+1];
	logic              done_q;
	logic [Q_W-1:0]    score_q;
	logic              zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= {in_data.num, FRAC_W'(0)};
		den_s[0] <= in_data.den;
		quo_s[0] <= '0;
	end

	// restoring divide, one quotient bit per stage, msb first
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		localparam int B = Q_W - 1 - j;
		logic [DIVD_W-1:0] dsh;
		logic              ge;

		assign dsh = DIVD_W'(den_s[j]) << B;
		assign ge  = (rem_s[j] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? rem_s[j] - dsh : rem_s[j];
			den_s[j+1] <= den_s[j];
			quo_s[j+1] <= quo_s[j] | (Q_W'(ge) << B);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		zero_q  <= (den_s[Q_W] == '0);
		score_q <= (den_s[Q_W] == '0) ? '0 : quo_s[Q_W];
	end

	assign done        = done_q;
	assign score       = score_q;
	assign zero_weight = zero_q;

endmodule

>>> rtl/core/fuzzy_two_input_sugeno_score.sv
// throughput: one transaction per cycle; busy rises only if the queue between
//   the membership front end and the 15-stage divider could overflow
// the receiver cannot stall; each result is shown for one cycle with done
// reset (arst_n low) clears all valid bits and the queue and loads the
//   heights 30, 60 and 80
module fuzzy_two_input_sugeno_score #(
	parameter int FIFO_DEPTH = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [15:0]                 income,
	input  logic [15:0]                 debt,
	output logic                        done,
	output logic [14:0]                 score,
	output logic                        zero_weight,
	input  logic                        cfg_we,
	input  logic [fzs_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [6:0]                  cfg_wdata
);
	import fzs_pkg::*;

	localparam int CW = $clog2(FIFO_DEPTH + 1);

	heights_t       heights_q;
	logic           accept;
	logic           fr_valid;
	frac_t          fr_data;
	logic [2:0]     inflight;
	logic           q_valid;
	frac_t          q_data;
	logic [CW-1:0]  q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heights_q.h_no    <= H_NO_RST;
			heights_q.h_maybe <= H_MAYBE_RST;
			heights_q.h_yes   <= H_YES_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_H_NO:    heights_q.h_no    <= cfg_wdata;
				CFG_H_MAYBE: heights_q.h_maybe <= cfg_wdata;
				CFG_H_YES:   heights_q.h_yes   <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	// reserve a queue slot for every transaction still in the front end
	assign busy   = ((CW + 3)'(q_count) + (CW + 3)'(inflight)) >= (CW + 3)'(FIFO_DEPTH);
	assign accept = start && !busy;

	fzs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.income    (income),
		.debt      (debt),
		.heights   (heights_q),
		.out_valid (fr_valid),
		.out_data  (fr_data),
		.inflight  (inflight)
	);

	fzs_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fr_valid),
		.wr_data  (fr_data),
		.rd_valid (q_valid),
		.rd_data  (q_data),
		.count    (q_count)
	);

	fzs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (q_valid),
		.in_data     (q_data),
		.done        (done),
		.score       (score),
		.zero_weight (zero_weight)
	);

endmodule

>>> rtl/core/fzs_checker.sv
module fzs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [14:0] score,
	input logic        zero_weight
);
	localparam int LAT = 24;

	logic [14:0] score_lim;
	assign score_lim = 15'd32512;

	// every accepted transaction comes back a fixed time later
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##24 done)
		else $error("accepted transaction without result");

	// no result without an accepted transaction
	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without transaction");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_weight |-> score == '0)
		else $error("zero weight with nonzero score");

	// heights are 7 bits, so the weighted average is at most 127.0
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> score <= score_lim)
		else $error("score out of range");

endmodule

bind fuzzy_two_input_sugeno_score fzs_checker u_fzs_checker (.*);
